@@ sv/gdrc_pkg.sv @@
// shared types, register indexes and divider selects for the grid ray caster
package gdrc_pkg;

    localparam int MAP_DIM_DEF       = 64;
    localparam int SCREEN_WIDTH_DEF  = 640;
    localparam int SCREEN_HEIGHT_DEF = 480;
    localparam int MAX_STEPS_DEF     = 128;

    localparam int DIVN_W = 33;
    localparam int DIVD_W = 24;

    localparam logic [2:0] CFG_PLAYER_X       = 3'd0;
    localparam logic [2:0] CFG_PLAYER_Y       = 3'd1;
    localparam logic [2:0] CFG_VIEW_DIR_X     = 3'd2;
    localparam logic [2:0] CFG_VIEW_DIR_Y     = 3'd3;
    localparam logic [2:0] CFG_CAMERA_PLANE_X = 3'd4;
    localparam logic [2:0] CFG_CAMERA_PLANE_Y = 3'd5;
    localparam logic [2:0] CFG_GRID_WIDTH     = 3'd6;
    localparam logic [2:0] CFG_GRID_HEIGHT    = 3'd7;

    localparam logic [1:0] DIV_CAM = 2'd0;
    localparam logic [1:0] DIV_DX  = 2'd1;
    localparam logic [1:0] DIV_DY  = 2'd2;
    localparam logic [1:0] DIV_LH  = 2'd3;

    localparam logic OP_WRITE_CELL = 1'b0;
    localparam logic OP_CAST_RAY   = 1'b1;

    typedef struct packed {
        logic       op;
        logic [9:0] screen_column;
        logic [5:0] cell_row;
        logic [5:0] cell_col;
        logic       cell_solid;
    } t_in_item;

    typedef struct packed {
        logic        wall_hit;
        logic        hit_side;
        logic [5:0]  hit_col;
        logic [5:0]  hit_row;
        logic [23:0] perp_distance;
        logic [15:0] slice_height;
        logic [9:0]  draw_top;
        logic [9:0]  draw_bottom;
        logic [15:0] wall_fraction;
    } t_out_item;

    typedef struct packed {
        logic       ld_item;
        logic       clr;
        logic       div_start;
        logic       div_load;
        logic [1:0] div_sel;
        logic       mul_cam;
        logic       add_rd;
        logic       side_init;
        logic       walk_step;
        logic       mark_hit;
        logic       perp_calc;
        logic       mul_frac;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic div_done;
        logic step_limit;
        logic border;
        logic cell_wall;
        logic out_free;
    } t_status;

endpackage

@@ sv/gdrc_div.sv @@
// shared restoring divider, one quotient bit per cycle
module gdrc_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [gdrc_pkg::DIVN_W-1:0]  i_dividend,
    input  logic [gdrc_pkg::DIVD_W-1:0]  i_divisor,
    output logic [gdrc_pkg::DIVN_W-1:0]  o_quotient,
    output logic                         o_done
);
    localparam int NW = gdrc_pkg::DIVN_W;
    localparam int DW = gdrc_pkg::DIVD_W;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_q;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_dvs;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW:0]   w_shift;
    logic          w_ge;
    logic [DW:0]   w_diff;

    assign w_shift = {r_rem, r_q[NW-1]};
    assign w_ge    = w_shift >= {1'b0, r_dvs};
    assign w_diff  = w_shift - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[NW-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DW-1:0] : w_shift[DW-1:0];
        end
    end

    assign o_quotient = r_q;
    assign o_done     = r_done;
endmodule

@@ sv/gdrc_dp.sv @@
// datapath: registers, map memory, multipliers, dda walk and result assembly
module gdrc_dp #(
    parameter int MAP_DIM       = gdrc_pkg::MAP_DIM_DEF,
    parameter int SCREEN_WIDTH  = gdrc_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = gdrc_pkg::SCREEN_HEIGHT_DEF,
    parameter int MAX_STEPS     = gdrc_pkg::MAX_STEPS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  gdrc_pkg::t_cmd       i_cmd,
    output gdrc_pkg::t_status    o_status,
    input  gdrc_pkg::t_in_item   i_in_item,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [2:0]           i_cfg_index,
    input  logic [23:0]          i_cfg_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output gdrc_pkg::t_out_item  o_out_item
);
    localparam int LB     = $clog2(MAP_DIM);
    localparam int AW     = 2 * LB;
    localparam int DEPTH  = 1 << AW;
    localparam int SDW    = 27 + $clog2(MAX_STEPS);
    localparam int NW     = $clog2(MAX_STEPS + 1);
    localparam int HALF_H = SCREEN_HEIGHT / 2;
    localparam logic [32:0] LH_NUM = 33'(SCREEN_HEIGHT * 65536);
    localparam logic [32:0] RECIP_NUM = 33'h1_0000_0000;
    // ceil(2^37 / width): exact floor of (col << 17) / width for every column
    localparam logic [37:0] CAM_RECIP =
        38'(((64'd1 << 37) + 64'(SCREEN_WIDTH) - 64'd1) / 64'(SCREEN_WIDTH));

    // configuration registers
    logic [23:0]        r_px, r_py;
    logic signed [17:0] r_dirx, r_diry, r_plx, r_ply;
    logic [6:0]         r_gw, r_gh;

    // ray working registers
    logic [9:0]         r_col;
    logic signed [17:0] r_cam;
    logic signed [35:0] r_prodx, r_prody;
    logic signed [21:0] r_rdx, r_rdy;
    logic [23:0]        r_dx, r_dy;
    logic [SDW-1:0]     r_sx, r_sy;
    logic signed [9:0]  r_mx, r_my;
    logic               r_side;
    logic               r_hit;
    logic [NW-1:0]      r_n;
    logic [23:0]        r_perp;
    logic [15:0]        r_lh;
    logic signed [46:0] r_prodf;

    logic               mem [DEPTH];
    logic               r_rdata;
    logic [AW-1:0]      r_clr_addr;

    gdrc_pkg::t_out_item r_out;
    logic                r_out_valid;

    logic [32:0] w_dividend;
    logic [23:0] w_divisor;
    logic [32:0] w_q;
    logic        w_div_done;
    logic [47:0] w_cam_prod;
    logic [21:0] w_absx, w_absy;
    logic [16:0] w_fx, w_fy;
    logic [40:0] w_sprodx, w_sprody;
    logic [8:0]  w_wmax, w_hmax;
    logic [SDW-1:0] w_pdiff;
    logic [14:0] w_half;
    logic [15:0] w_bsum;
    logic [9:0]  w_top, w_bot;
    logic [15:0] w_frac;
    logic [10:0] w_col_in;
    logic        w_cell_ok;

    assign w_absx = r_rdx[21] ? 22'(-r_rdx) : 22'(r_rdx);
    assign w_absy = r_rdy[21] ? 22'(-r_rdy) : 22'(r_rdy);

    // camera offset by reciprocal multiplication
    assign w_cam_prod = 48'(r_col) * 48'(CAM_RECIP);

    always_comb begin
        case (i_cmd.div_sel)
            gdrc_pkg::DIV_DX: begin
                w_dividend = RECIP_NUM;
                w_divisor  = 24'(w_absx);
            end
            gdrc_pkg::DIV_DY: begin
                w_dividend = RECIP_NUM;
                w_divisor  = 24'(w_absy);
            end
            default: begin
                w_dividend = LH_NUM;
                w_divisor  = r_perp;
            end
        endcase
    end

    gdrc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_quotient (w_q),
        .o_done     (w_div_done)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px   <= 24'h010000;
            r_py   <= 24'h010000;
            r_dirx <= -18'sd65536;
            r_diry <= '0;
            r_plx  <= '0;
            r_ply  <= 18'sd43253;
            r_gw   <= 7'd64;
            r_gh   <= 7'd64;
        end else if (i_cfg_valid && i_cfg_ready) begin
            case (i_cfg_index)
                gdrc_pkg::CFG_PLAYER_X:       r_px   <= i_cfg_data;
                gdrc_pkg::CFG_PLAYER_Y:       r_py   <= i_cfg_data;
                gdrc_pkg::CFG_VIEW_DIR_X:     r_dirx <= i_cfg_data[17:0];
                gdrc_pkg::CFG_VIEW_DIR_Y:     r_diry <= i_cfg_data[17:0];
                gdrc_pkg::CFG_CAMERA_PLANE_X: r_plx  <= i_cfg_data[17:0];
                gdrc_pkg::CFG_CAMERA_PLANE_Y: r_ply  <= i_cfg_data[17:0];
                gdrc_pkg::CFG_GRID_WIDTH:     r_gw   <= i_cfg_data[6:0];
                gdrc_pkg::CFG_GRID_HEIGHT:    r_gh   <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // map memory with clearing sweep
    assign w_cell_ok = (32'(i_in_item.cell_row) < MAP_DIM) &&
                       (32'(i_in_item.cell_col) < MAP_DIM);

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            mem[r_clr_addr] <= 1'b0;
        end else if (i_cmd.ld_item && i_in_item.op == gdrc_pkg::OP_WRITE_CELL && w_cell_ok) begin
            mem[{LB'(i_in_item.cell_row), LB'(i_in_item.cell_col)}] <= i_in_item.cell_solid;
        end
        r_rdata <= mem[{r_my[LB-1:0], r_mx[LB-1:0]}];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // ray setup and walk
    assign w_col_in = (11'(i_in_item.screen_column) >= 11'(SCREEN_WIDTH)) ?
                      11'(SCREEN_WIDTH - 1) : 11'(i_in_item.screen_column);
    assign w_fx = r_rdx[21] ? {1'b0, r_px[15:0]} : 17'h10000 - {1'b0, r_px[15:0]};
    assign w_fy = r_rdy[21] ? {1'b0, r_py[15:0]} : 17'h10000 - {1'b0, r_py[15:0]};
    assign w_sprodx = 41'(w_fx) * 41'(r_dx);
    assign w_sprody = 41'(w_fy) * 41'(r_dy);
    assign w_pdiff = r_side ? r_sy - SDW'(r_dy) : r_sx - SDW'(r_dx);

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_item) begin
            r_col <= w_col_in[9:0];
            r_hit <= 1'b0;
        end
        if (i_cmd.div_load) begin
            case (i_cmd.div_sel)
                gdrc_pkg::DIV_CAM:
                    r_cam <= $signed({1'b0, w_cam_prod[36:20]}) - 18'sd65536;
                gdrc_pkg::DIV_DX:
                    r_dx <= (r_rdx == '0 || w_q > 33'hFFFFFF) ? 24'hFFFFFF : w_q[23:0];
                gdrc_pkg::DIV_DY:
                    r_dy <= (r_rdy == '0 || w_q > 33'hFFFFFF) ? 24'hFFFFFF : w_q[23:0];
                default:
                    r_lh <= (r_perp == '0 || w_q > 33'hFFFF) ? 16'hFFFF : w_q[15:0];
            endcase
        end
        if (i_cmd.mul_cam) begin
            r_prodx <= r_plx * r_cam;
            r_prody <= r_ply * r_cam;
        end
        if (i_cmd.add_rd) begin
            r_rdx <= {{4{r_dirx[17]}}, r_dirx} + {{2{r_prodx[35]}}, r_prodx[35:16]};
            r_rdy <= {{4{r_diry[17]}}, r_diry} + {{2{r_prody[35]}}, r_prody[35:16]};
        end
        if (i_cmd.side_init) begin
            r_sx   <= SDW'(w_sprodx[40:16]);
            r_sy   <= SDW'(w_sprody[40:16]);
            r_mx   <= $signed(10'(r_px[23:16]));
            r_my   <= $signed(10'(r_py[23:16]));
            r_n    <= '0;
            r_side <= 1'b0;
        end
        if (i_cmd.walk_step) begin
            r_n <= r_n + 1'b1;
            if (r_sx < r_sy) begin
                r_sx   <= r_sx + SDW'(r_dx);
                r_mx   <= r_rdx[21] ? r_mx - 10'sd1 : r_mx + 10'sd1;
                r_side <= 1'b0;
            end else begin
                r_sy   <= r_sy + SDW'(r_dy);
                r_my   <= r_rdy[21] ? r_my - 10'sd1 : r_my + 10'sd1;
                r_side <= 1'b1;
            end
        end
        if (i_cmd.mark_hit) begin
            r_hit <= 1'b1;
        end
        if (i_cmd.perp_calc) begin
            r_perp <= (|w_pdiff[SDW-1:24]) ? 24'hFFFFFF : w_pdiff[23:0];
        end
        if (i_cmd.mul_frac) begin
            r_prodf <= $signed({1'b0, r_perp}) * (r_side ? r_rdx : r_rdy);
        end
    end

    assign w_wmax = (9'(r_gw) > 9'(MAP_DIM)) ? 9'(MAP_DIM) : 9'(r_gw);
    assign w_hmax = (9'(r_gh) > 9'(MAP_DIM)) ? 9'(MAP_DIM) : 9'(r_gh);

    // result fields
    assign w_half = r_lh[15:1];
    assign w_top  = (16'(w_half) > 16'(HALF_H)) ? '0 : 10'(16'(HALF_H) - 16'(w_half));
    assign w_bsum = 16'(w_half) + 16'(HALF_H);
    assign w_bot  = (w_bsum >= 16'(SCREEN_HEIGHT)) ? 10'(SCREEN_HEIGHT - 1) : w_bsum[9:0];
    assign w_frac = (r_side ? r_px[15:0] : r_py[15:0]) + r_prodf[31:16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.wall_hit      <= r_hit;
            r_out.hit_side      <= r_side;
            r_out.hit_col       <= r_mx[5:0];
            r_out.hit_row       <= r_my[5:0];
            r_out.perp_distance <= r_perp;
            r_out.slice_height  <= r_lh;
            r_out.draw_top      <= w_top;
            r_out.draw_bottom   <= w_bot;
            r_out.wall_fraction <= w_frac;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign o_status.clr_done   = (r_clr_addr == AW'(DEPTH - 1));
    assign o_status.div_done   = w_div_done;
    assign o_status.step_limit = (r_n == NW'(MAX_STEPS));
    assign o_status.border     = (r_mx <= 10'sd0) || (r_my <= 10'sd0) ||
                                 (r_mx >= $signed({1'b0, w_wmax})) ||
                                 (r_my >= $signed({1'b0, w_hmax}));
    assign o_status.cell_wall  = r_rdata;
    assign o_status.out_free   = !r_out_valid || !i_out_stall;

    a_out_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || !i_out_stall))
        else $error("result loaded over an item not yet taken");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.walk_step |-> (r_n < NW'(MAX_STEPS)))
        else $error("walk stepped past the step limit");

    a_zero_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.div_load && i_cmd.div_sel == gdrc_pkg::DIV_LH && r_perp == '0)
        |=> (r_lh == 16'hFFFF))
        else $error("zero distance did not saturate line height");

    a_hit_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mark_hit |-> (!o_status.border && r_rdata))
        else $error("hit marked outside the grid or on an open cell");
endmodule

@@ sv/gdrc_ctrl.sv @@
// controller state machine sequencing map clear, map writes, ray setup, walk and result
module gdrc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_op,
    output logic                o_in_stall,
    output gdrc_pkg::t_cmd      o_cmd,
    input  gdrc_pkg::t_status   i_status
);
    localparam logic [3:0] S_CLR     = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_CAM     = 4'd2;
    localparam logic [3:0] S_MUL     = 4'd4;
    localparam logic [3:0] S_RD      = 4'd5;
    localparam logic [3:0] S_DX      = 4'd6;
    localparam logic [3:0] S_DXW     = 4'd7;
    localparam logic [3:0] S_DY      = 4'd8;
    localparam logic [3:0] S_DYW     = 4'd9;
    localparam logic [3:0] S_SIDE    = 4'd10;
    localparam logic [3:0] S_STEP    = 4'd11;
    localparam logic [3:0] S_CHK     = 4'd12;
    localparam logic [3:0] S_CELL    = 4'd13;
    localparam logic [3:0] S_PERP    = 4'd14;
    localparam logic [3:0] S_LH      = 4'd15;

    logic [3:0] r_state, n_state;
    logic       r_lh_wait, n_lh_wait;
    logic       r_fin, n_fin;
    logic       w_accept;

    assign w_accept   = i_in_valid && r_state == S_IDLE && !r_lh_wait && !r_fin;
    assign o_in_stall = !(r_state == S_IDLE && !r_lh_wait && !r_fin);

    always_comb begin
        n_state   = r_state;
        n_lh_wait = r_lh_wait;
        n_fin     = r_fin;
        o_cmd     = '0;
        o_cmd.ld_item = w_accept;
        case (r_state)
            S_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_status.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                // line height wait and final load share the idle code
                if (r_lh_wait) begin
                    o_cmd.div_sel = gdrc_pkg::DIV_LH;
                    if (i_status.div_done) begin
                        o_cmd.div_load = 1'b1;
                        n_lh_wait      = 1'b0;
                        n_fin          = 1'b1;
                    end
                end else if (r_fin) begin
                    if (i_status.out_free) begin
                        o_cmd.out_load = 1'b1;
                        n_fin          = 1'b0;
                    end
                end else if (w_accept && i_op == gdrc_pkg::OP_CAST_RAY) begin
                    n_state = S_CAM;
                end
            end
            S_CAM: begin
                // camera offset comes from a combinational reciprocal product, registered here
                o_cmd.div_sel  = gdrc_pkg::DIV_CAM;
                o_cmd.div_load = 1'b1;
                n_state        = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_cam = 1'b1;
                n_state       = S_RD;
            end
            S_RD: begin
                o_cmd.add_rd = 1'b1;
                n_state      = S_DX;
            end
            S_DX: begin
                o_cmd.div_sel   = gdrc_pkg::DIV_DX;
                o_cmd.div_start = 1'b1;
                n_state         = S_DXW;
            end
            S_DXW: begin
                o_cmd.div_sel = gdrc_pkg::DIV_DX;
                if (i_status.div_done) begin
                    o_cmd.div_load = 1'b1;
                    n_state        = S_DY;
                end
            end
            S_DY: begin
                o_cmd.div_sel   = gdrc_pkg::DIV_DY;
                o_cmd.div_start = 1'b1;
                n_state         = S_DYW;
            end
            S_DYW: begin
                o_cmd.div_sel = gdrc_pkg::DIV_DY;
                if (i_status.div_done) begin
                    o_cmd.div_load = 1'b1;
                    n_state        = S_SIDE;
                end
            end
            S_SIDE: begin
                o_cmd.side_init = 1'b1;
                n_state         = S_STEP;
            end
            S_STEP: begin
                if (i_status.step_limit) begin
                    n_state = S_PERP;
                end else begin
                    o_cmd.walk_step = 1'b1;
                    n_state         = S_CHK;
                end
            end
            S_CHK: begin
                // map read of the new cell is in flight here
                n_state = i_status.border ? S_PERP : S_CELL;
            end
            S_CELL: begin
                if (i_status.cell_wall) begin
                    o_cmd.mark_hit = 1'b1;
                    n_state        = S_PERP;
                end else begin
                    n_state = S_STEP;
                end
            end
            S_PERP: begin
                o_cmd.perp_calc = 1'b1;
                n_state         = S_LH;
            end
            S_LH: begin
                o_cmd.div_sel   = gdrc_pkg::DIV_LH;
                o_cmd.div_start = 1'b1;
                o_cmd.mul_frac  = 1'b1;
                n_lh_wait       = 1'b1;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_lh_wait <= 1'b0;
            r_fin     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_lh_wait <= n_lh_wait;
            r_fin     <= n_fin;
        end
    end
endmodule

@@ sv/grid_dda_ray_caster.sv @@
// top level of the grid ray caster: controller plus datapath
// a ray item uses the shared 33-bit divider three times, and each grid step
// goes through a step, a map read and a wall test
// a map write takes effect as it is accepted; one item is worked on at a time
// the result register lets the next item in while a result waits to be taken
// after reset the map is cleared, one cell a cycle, 2^(2*clog2(MAP_DIM)) cells
// (4096 by default), input stalled meanwhile; configuration resets to its defaults
module grid_dda_ray_caster #(
    parameter int MAP_DIM       = gdrc_pkg::MAP_DIM_DEF,
    parameter int SCREEN_WIDTH  = gdrc_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = gdrc_pkg::SCREEN_HEIGHT_DEF,
    parameter int MAX_STEPS     = gdrc_pkg::MAX_STEPS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  gdrc_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output gdrc_pkg::t_out_item  o_out_item,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [2:0]           i_cfg_index,
    input  logic [23:0]          i_cfg_data
);
    gdrc_pkg::t_cmd    w_cmd;
    gdrc_pkg::t_status w_status;

    assign o_cfg_ready = 1'b1;

    gdrc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_in_item.op),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd),
        .i_status   (w_status)
    );

    gdrc_dp #(
        .MAP_DIM       (MAP_DIM),
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .MAX_STEPS     (MAX_STEPS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_item   (i_in_item),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );
endmodule
